>>> design/dgf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the decimal grouped formatter.
// Used by the front, back, top level and testbench; depends on nothing.
package dgf_pkg;

   // Field widths
   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 7;
   localparam int DIGIT_W = 4;
   localparam int LEN_W   = 4;

   // Values below this get a leading space
   localparam logic [VALUE_W-1:0] PAD_LIMIT = 32'd10000000;

   // Divide by ten: q = (t * RECIP_10) >> RECIP_SHIFT, exact for 32-bit t
   localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCCCCCD;
   localparam int                 RECIP_SHIFT = 35;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'd32;
   localparam logic [CHAR_W-1:0] CH_DOT   = 7'd46;

   // Descriptor of one converted item, next to its digits in the queue
   typedef struct packed {
      logic             pad;
      logic [LEN_W-1:0] len;
   } dgf_hdr_type;

   localparam int HDR_W = $bits(dgf_hdr_type);

   typedef enum logic {
      FRONT_IDLE,
      FRONT_CONV
   } dgf_front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } dgf_back_state_type;

   // Group phase at the first character: 2 - (len mod 3)
   function automatic logic [1:0] phase_init(input logic [LEN_W-1:0] len);
      logic [1:0] ph;
      case (len) inside
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: ph = 2'd2;
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       ph = 2'd1;
         default:                              ph = 2'd0;
      endcase
      return ph;
   endfunction

endpackage

>>> design/dgf_front.sv
`timescale 1ns / 1ps
// Front end: takes a value, peels off one decimal digit per cycle and
// pushes digits plus length into the queue. Depends on dgf_pkg.
module dgf_front #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dgf_pkg::VALUE_W-1:0] req_value,
   input  logic                        q_full,
   output logic                        q_push,
   output dgf_pkg::dgf_hdr_type        q_hdr,
   output logic [MAX_DIGITS*dgf_pkg::DIGIT_W-1:0] q_digits
);
   import dgf_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   dgf_front_state_type state_ff, state_in;
   logic [VALUE_W-1:0]   t_ff, t_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   logic                 pad_ff, pad_in;
   logic [DIGIT_W-1:0]   store_ff [MAX_DIGITS];

   logic [2*VALUE_W-1:0] prod;
   logic [VALUE_W-1:0]   quot;
   logic [DIGIT_W-1:0]   ten_q_lo;
   logic [DIGIT_W-1:0]   digit;
   logic [IDX_W-1:0]     wr_idx;
   logic                 wr_en;
   logic [LEN_W:0]       len_sum;

   // Divide by ten via reciprocal; remainder only needs the low nibble
   assign prod     = t_ff * RECIP_10;
   assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
   assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
   assign digit    = t_ff[DIGIT_W-1:0] - ten_q_lo;
   assign wr_idx   = IDX_W'(count_ff);

   // Length with the pad slot, saturated at the store depth
   assign len_sum = (LEN_W+1)'(count_ff) + (LEN_W+1)'(pad_ff);
   always_comb begin
      q_hdr.pad = pad_ff;
      if (len_sum > (LEN_W+1)'(MAX_DIGITS)) begin
         q_hdr.len = LEN_W'(MAX_DIGITS);
      end else begin
         q_hdr.len = len_sum[LEN_W-1:0];
      end
   end

   // Flatten the digit store for the queue
   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         q_digits[k*DIGIT_W +: DIGIT_W] = store_ff[k];
      end
   end

   assign busy = (state_ff == FRONT_CONV);

   // Next state and outputs
   always_comb begin
      state_in = state_ff;
      t_in     = t_ff;
      count_in = count_ff;
      pad_in   = pad_ff;
      wr_en    = 1'b0;
      q_push   = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            if (start) begin
               state_in = FRONT_CONV;
               t_in     = req_value;
               pad_in   = (req_value < PAD_LIMIT);
               count_in = '0;
            end
         end
         FRONT_CONV: begin
            if (t_ff != '0) begin
               t_in     = quot;
               count_in = count_ff + 1'b1;
               wr_en    = (count_ff < MAX_DIGITS);
            end else if (!q_full) begin
               q_push   = 1'b1;
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff     <= t_in;
      count_ff <= count_in;
      pad_ff   <= pad_in;
      if (wr_en) begin
         store_ff[wr_idx] <= digit;
      end
   end

endmodule

>>> design/dgf_queue.sv
`timescale 1ns / 1ps
// Two-entry item queue between front and back.
// Depends on nothing outside this file.
module dgf_queue #(
   parameter int DATA_W = 45
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/dgf_back.sv
`timescale 1ns / 1ps
// Back end: pops a converted item and emits one character per cycle,
// inserting separators between groups of three. Depends on dgf_pkg.
module dgf_back #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  dgf_pkg::dgf_hdr_type        q_hdr,
   input  logic [MAX_DIGITS*dgf_pkg::DIGIT_W-1:0] q_digits,
   output logic                        q_pop,
   output logic                        rsp_strobe,
   output logic [dgf_pkg::CHAR_W-1:0]  rsp_character,
   output logic                        rsp_final_char
);
   import dgf_pkg::*;

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   dgf_back_state_type state_ff, state_in;
   logic [DIGIT_W-1:0] digits_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0] digits_in [MAX_DIGITS];
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic               pad_ff, pad_in;
   logic               first_ff, first_in;
   logic [1:0]         phase_ff, phase_in;
   logic               dot_ff, dot_in;
   logic               strobe_ff, strobe_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               fin_ff, fin_in;

   logic               want_load;
   logic               load;
   logic [DIGIT_W-1:0] cur_digit;

   assign cur_digit = digits_ff[IDX_W'(pos_ff)];

   assign rsp_strobe     = strobe_ff;
   assign rsp_character  = char_ff;
   assign rsp_final_char = fin_ff;
   assign q_pop          = load;

   // Next state and character selection
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      pad_in    = pad_ff;
      first_in  = first_ff;
      phase_in  = phase_ff;
      dot_in    = dot_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      fin_in    = 1'b0;
      want_load = 1'b0;
      case (state_ff)
         BACK_IDLE: want_load = 1'b1;
         BACK_EMIT: begin
            strobe_in = 1'b1;
            if (dot_ff) begin
               char_in = CH_DOT;
               dot_in  = 1'b0;
            end else begin
               if (first_ff && pad_ff) begin
                  char_in = CH_SPACE;
               end else begin
                  char_in = CH_ZERO + CHAR_W'(cur_digit);
               end
               fin_in   = (pos_ff == '0);
               dot_in   = (phase_ff == 2'd1) && (pos_ff != '0);
               phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
               pos_in   = pos_ff - 1'b1;
               first_in = 1'b0;
               if (pos_ff == '0) begin
                  state_in  = BACK_IDLE;
                  want_load = 1'b1;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase

      // Start the next item right behind the last character
      load = want_load && q_valid;
      if (load) begin
         state_in = BACK_EMIT;
         pad_in   = q_hdr.pad;
         pos_in   = q_hdr.len - 1'b1;
         first_in = 1'b1;
         phase_in = phase_init(q_hdr.len);
         dot_in   = 1'b0;
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         digits_in[k] = load ? q_digits[k*DIGIT_W +: DIGIT_W] : digits_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BACK_IDLE;
         strobe_ff <= 1'b0;
         fin_ff    <= 1'b0;
         dot_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         fin_ff    <= fin_in;
         dot_ff    <= dot_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      pad_ff    <= pad_in;
      first_ff  <= first_in;
      phase_ff  <= phase_in;
      char_ff   <= char_in;
      digits_ff <= digits_in;
   end

endmodule

>>> design/decimal_grouped_formatter_top.sv
`timescale 1ns / 1ps
// Decimal grouped formatter: renders a 32-bit unsigned value as decimal
// ASCII, one character per cycle, with '.' between groups of three.
//
// Input: drive req_value and raise start; the item is taken at an edge
// where start is high and busy is low. busy stays high while the front
// end converts the value digit by digit in the divide-by-ten loop and
// while it waits on a full queue; a new item is taken only once the
// last one has been pushed into the queue.
// Output: each character appears on rsp_character for one cycle with
// rsp_strobe high; rsp_final_char marks the last one. The back end emits
// one character per cycle, 1 to 13 per item. Sustained throughput is set
// by the slower of the conversion and the character count of the item.
// A two-entry queue holds converted items so conversion overlaps output.
// The receiver cannot stall; results are never held back or dropped.
// Reset: synchronous, active high; clears the control state, empties the
// queue and drops any item in flight. No clearing pass is needed.
module decimal_grouped_formatter_top #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dgf_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_strobe,
   output logic [dgf_pkg::CHAR_W-1:0]  rsp_character,
   output logic                        rsp_final_char
);
   import dgf_pkg::*;

   localparam int DIG_W  = MAX_DIGITS * DIGIT_W;
   localparam int DATA_W = HDR_W + DIG_W;

   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   dgf_hdr_type       push_hdr;
   logic [DIG_W-1:0]  push_digits;
   logic [DATA_W-1:0] pop_data;
   dgf_hdr_type       pop_hdr;
   logic [DIG_W-1:0]  pop_digits;

   assign pop_hdr    = dgf_hdr_type'(pop_data[DATA_W-1 -: HDR_W]);
   assign pop_digits = pop_data[DIG_W-1:0];

   // Conversion
   dgf_front #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_hdr     (push_hdr),
      .q_digits  (push_digits)
   );

   // Decoupling queue
   dgf_queue #(
      .DATA_W(DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_hdr, push_digits}),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   // Character emission
   dgf_back #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_hdr          (pop_hdr),
      .q_digits       (pop_digits),
      .q_pop          (q_pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_character  (rsp_character),
      .rsp_final_char (rsp_final_char)
   );

   // Front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   // Back only pops a present item
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue pop while empty");

   // A separator is always followed at once by a digit
   a_dot_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_character == CH_DOT |=>
         rsp_strobe && rsp_character != CH_DOT && rsp_character != CH_SPACE)
      else $error("separator not followed by a digit");

   // The leading space only opens an item
   a_space_first: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_character == CH_SPACE |->
         !$past(rsp_strobe) || $past(rsp_final_char))
      else $error("space inside an item");

endmodule

>>> tb/sv/tb_decimal_grouped_formatter_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for decimal_grouped_formatter_top: directed and random values
// are rendered by an in-bench predictor and compared per character. Depends on dgf_pkg.
module tb_decimal_grouped_formatter_top;
   import dgf_pkg::*;

   localparam int MAX_DIGITS   = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 500;
   localparam int QUIET_TAIL   = 60;     // last items are sent without idling
   localparam int DRAIN_CYCLES = 40;     // beyond the worst conversion plus emit time
   localparam int CYCLE_LIMIT  = 200000;

   // One expected character on the response side
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              final_char;
   } char_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [CHAR_W-1:0]  rsp_character;
   logic               rsp_final_char;

   logic [VALUE_W-1:0] pending_values [$];
   char_item_type      expected_chars [$];
   int unsigned        total_items = 0;
   int unsigned        accepted_items = 0;
   int unsigned        cycle_count = 0;
   bit                 failed = 1'b0;

   // driver scratch
   int unsigned        gap_left = 0;
   int unsigned        calm_left = 0;
   logic               next_start;
   logic [VALUE_W-1:0] next_value;

   decimal_grouped_formatter_top #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_final_char(rsp_final_char)
   );

   always #2 clock = ~clock;

   // Render one value into the expected character stream
   function automatic void render_value_chars(input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] digit_buf [MAX_DIGITS];
      int unsigned        n_chars;
      int unsigned        i;
      logic               pad;
      logic [1:0]         grp_pos;
      char_item_type      item;
      pad = (value < PAD_LIMIT);
      n_chars = pad ? 1 : 0;
      rest = value;
      while (rest != 0) begin
         n_chars++;
         rest = rest / 32'd10;
      end
      if (n_chars > MAX_DIGITS) n_chars = MAX_DIGITS;
      // digits, least significant at the right end; the pad slot gets a zero
      rest = value;
      for (i = 0; i < n_chars; i++) begin
         digit_buf[n_chars - 1 - i] = DIGIT_W'(rest % 32'd10);
         rest = rest / 32'd10;
      end
      grp_pos = 2'(2 - (n_chars % 3));
      for (i = 0; i < n_chars; i++) begin
         item.character  = (pad && i == 0) ? CH_SPACE : CHAR_W'(CH_ZERO + digit_buf[i]);
         item.final_char = (i + 1 == n_chars);
         expected_chars.push_back(item);
         // separator closes a group unless this was the last character
         if (grp_pos == 2'd1 && !item.final_char) begin
            item.character  = CH_DOT;
            item.final_char = 1'b0;
            expected_chars.push_back(item);
         end
         grp_pos = (grp_pos == 2'd2) ? 2'd0 : grp_pos + 2'd1;
      end
   endfunction

   // Driver: hold start until taken, then fetch the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         req_value <= '0;
      end else begin
         next_start = start;
         next_value = req_value;
         if (start && !busy) begin
            render_value_chars(req_value);
            accepted_items++;
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_values.size() > 0) begin
               if (calm_left > 0) calm_left--;
               if (pending_values.size() > QUIET_TAIL && calm_left == 0 &&
                   $urandom_range(0, 4) == 0) begin
                  // this cycle is the first of the idle burst
                  gap_left = $urandom_range(0, 5);
               end else begin
                  if (calm_left == 0 && $urandom_range(0, 29) == 0)
                     calm_left = $urandom_range(10, 40);
                  next_start = 1'b1;
                  next_value = pending_values.pop_front();
               end
            end
         end
         start     <= next_start;
         req_value <= next_value;
      end
   end

   // Monitor: every strobe must match the oldest expected character
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected character: actual %0d final_char %0b",
                   rsp_character, rsp_final_char);
            failed = 1'b1;
         end else begin
            if (rsp_character !== expected_chars[0].character) begin
               $error("character mismatch: expected %0d, actual %0d",
                      expected_chars[0].character, rsp_character);
               failed = 1'b1;
            end
            if (rsp_final_char !== expected_chars[0].final_char) begin
               $error("final_char mismatch: expected %0b, actual %0b",
                      expected_chars[0].final_char, rsp_final_char);
               failed = 1'b1;
            end
            void'(expected_chars.pop_front());
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [VALUE_W-1:0] directed [];
      longint unsigned lo;
      longint unsigned hi;
      int unsigned     n_digits;
      int unsigned     sel;
      int unsigned     k;

      directed = '{
         32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
         32'd12345, 32'd123456, 32'd999999, 32'd1000000, 32'd9999999,
         32'd10000000, 32'd10000001, 32'd99999999, 32'd100000000,
         32'd999999999, 32'd1000000000, 32'hFFFFFFFF, 32'h80000000,
         32'h55555555, 32'hAAAAAAAA, 32'd1234567890
      };
      foreach (directed[j]) pending_values.push_back(directed[j]);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            // uniform over digit count, then uniform inside that decade
            n_digits = $urandom_range(1, 10);
            lo = 1;
            repeat (n_digits - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (n_digits == 1) lo = 0;
            if (hi > 64'hFFFFFFFF) hi = 64'hFFFFFFFF;
            pending_values.push_back($urandom_range(VALUE_W'(hi), VALUE_W'(lo)));
         end else if (sel < 7) begin
            // around the leading-space threshold
            pending_values.push_back(PAD_LIMIT - 4 + $urandom_range(0, 8));
         end else begin
            pending_values.push_back($urandom);
         end
      end
      total_items = pending_values.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_items < total_items) @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_chars.size() != 0) begin
         $error("%0d expected characters never arrived", expected_chars.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
